[hdl/i2c_master_transfer_sequencer_unit_assert.svh]
// Assertion macros shared by the I2C transfer sequencer modules.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define I2CSEQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2cseq assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define I2CSEQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2cseq assertion failed");

`endif

[hdl/i2cseq_pkg.sv]
// Shared constants and types of the I2C transfer sequencer.
`default_nettype none

package i2cseq_pkg;

  localparam int unsigned FifoDepth  = 16;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned BatchLimit = (FifoDepth < 16) ? FifoDepth : 16;
  localparam int unsigned BatchW     = $clog2(BatchLimit + 1);
  localparam int unsigned WideW      = (CountBits > BatchW) ? CountBits : BatchW;

  // Event codes; the top three are unknown and ignored.
  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_TX_EMPTY = 3'd1,
    CMD_RX_BYTE  = 3'd2,
    CMD_STOP     = 3'd3,
    CMD_BUS_ERR  = 3'd4,
    CMD_RSVD5    = 3'd5,
    CMD_RSVD6    = 3'd6,
    CMD_RSVD7    = 3'd7
  } cmd_e;

  // Transfer phase codes.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WRITE = 2'd1;
  localparam logic [1:0] PH_READ  = 2'd2;

  typedef enum logic [2:0] {
    KIND_CMD    = 3'd0,
    KIND_RX     = 3'd1,
    KIND_TARGET = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_FAIL   = 3'd4
  } kind_e;

  // One result transfer.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        is_read;
    logic        stop;
    logic        restart;
    logic [3:0]  thr;
    logic [9:0]  addr;
    logic        err_arb;
    logic        err_ovr;
    logic        last;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
  } seq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit;
    logic more;
  } seq_stat_t;

endpackage

`default_nettype wire

[hdl/i2cseq_dp.sv]
// Datapath: item latch, transfer state, result generation and output register.
`default_nettype none

module i2cseq_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cseq_pkg::seq_cmd_t  ctl_i,
  output i2cseq_pkg::seq_stat_t stat_o,
  input  logic [2:0]            cmd_i,
  input  logic [9:0]            target_addr_i,
  input  logic [15:0]           tx_count_i,
  input  logic [15:0]           rx_count_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  arb_lost_i,
  input  logic                  overrun_i,
  output i2cseq_pkg::res_t      res_o
);
  import i2cseq_pkg::*;

  `include "i2c_master_transfer_sequencer_unit_assert.svh"

  // Latched item.
  logic [2:0]           it_cmd_q;
  logic [9:0]           it_addr_q;
  logic [CountBits-1:0] it_txc_q;
  logic [CountBits-1:0] it_rxc_q;
  logic [7:0]           it_byte_q;
  logic                 it_al_q;
  logic                 it_ov_q;
  logic                 first_q;

  // Transfer state.
  logic [1:0]           phase_q, phase_d;
  logic [CountBits-1:0] wl_q, wl_d;
  logic [CountBits-1:0] rl_q, rl_d;
  logic                 arm_q, arm_d;
  logic [BatchW-1:0]    outst_q, outst_d;
  logic                 arb_q, arb_d;
  logic                 ovf_q, ovf_d;
  logic [BatchW-1:0]    bl_q, bl_d;
  logic [3:0]           thr_q, thr_d;

  res_t                 res_q, res_d;
  logic                 emit, more, busy;
  logic [WideW-1:0]     rl_wide;
  logic [BatchW-1:0]    batch;

  assign busy    = (phase_q == PH_WRITE) || (phase_q == PH_READ);
  assign rl_wide = WideW'(rl_q);
  assign batch   = (rl_wide < WideW'(BatchLimit)) ? BatchW'(rl_wide) : BatchW'(BatchLimit);

  always_comb begin
    phase_d = phase_q;
    wl_d    = wl_q;
    rl_d    = rl_q;
    arm_d   = arm_q;
    outst_d = outst_q;
    arb_d   = arb_q;
    ovf_d   = ovf_q;
    bl_d    = bl_q;
    thr_d   = thr_q;
    res_d   = '0;
    emit    = 1'b0;
    more    = 1'b0;
    unique case (it_cmd_q)
      CMD_START: begin
        if (first_q) begin
          wl_d       = it_txc_q;
          rl_d       = it_rxc_q;
          arm_d      = 1'b0;
          outst_d    = '0;
          arb_d      = 1'b0;
          ovf_d      = 1'b0;
          emit       = 1'b1;
          res_d.kind = KIND_TARGET;
          res_d.addr = it_addr_q;
          if (it_txc_q != '0) begin
            phase_d = PH_WRITE;
          end else if (it_rxc_q != '0) begin
            phase_d = PH_READ;
          end else begin
            phase_d = PH_IDLE;
            more    = 1'b1;
          end
        end else begin
          emit       = 1'b1;
          res_d.kind = KIND_DONE;
        end
      end
      CMD_TX_EMPTY: begin
        if (!first_q) begin
          // continue a read batch
          emit          = 1'b1;
          res_d.kind    = KIND_CMD;
          res_d.is_read = 1'b1;
          res_d.stop    = (rl_q == CountBits'(1));
          res_d.thr     = thr_q;
          rl_d          = rl_q - CountBits'(1);
          bl_d          = bl_q - BatchW'(1);
          more          = (bl_q != BatchW'(1));
        end else if (phase_q == PH_WRITE) begin
          if (wl_q != '0) begin
            emit       = 1'b1;
            res_d.kind = KIND_CMD;
            res_d.data = it_byte_q;
            res_d.stop = (wl_q == CountBits'(1));
            wl_d       = wl_q - CountBits'(1);
          end
        end else if (phase_q == PH_READ) begin
          if ((rl_q != '0) && (outst_q == '0)) begin
            emit          = 1'b1;
            thr_d         = 4'(batch - BatchW'(1));
            res_d.kind    = KIND_CMD;
            res_d.is_read = 1'b1;
            res_d.stop    = (rl_q == CountBits'(1));
            res_d.restart = arm_q;
            res_d.thr     = thr_d;
            rl_d          = rl_q - CountBits'(1);
            arm_d         = 1'b0;
            outst_d       = batch;
            bl_d          = batch - BatchW'(1);
            more          = (batch != BatchW'(1));
          end
        end
      end
      CMD_RX_BYTE: begin
        if (phase_q == PH_READ) begin
          emit       = 1'b1;
          res_d.kind = KIND_RX;
          res_d.data = it_byte_q;
          if (outst_q != '0) begin
            outst_d = outst_q - BatchW'(1);
          end
        end
      end
      CMD_STOP: begin
        if ((phase_q == PH_WRITE) && (rl_q != '0)) begin
          phase_d = PH_READ;
          arm_d   = 1'b1;
        end else if (busy) begin
          phase_d    = PH_IDLE;
          emit       = 1'b1;
          res_d.kind = KIND_DONE;
        end
      end
      CMD_BUS_ERR: begin
        if (busy) begin
          arb_d         = arb_q | it_al_q;
          ovf_d         = ovf_q | it_ov_q;
          phase_d       = PH_IDLE;
          emit          = 1'b1;
          res_d.kind    = KIND_FAIL;
          res_d.err_arb = arb_d;
          res_d.err_ovr = ovf_d;
        end
      end
      default: ;
    endcase
    res_d.last = emit && !more;
  end

  assign stat_o.emit = emit;
  assign stat_o.more = more;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b0;
      phase_q <= PH_IDLE;
      wl_q    <= '0;
      rl_q    <= '0;
      arm_q   <= 1'b0;
      outst_q <= '0;
      arb_q   <= 1'b0;
      ovf_q   <= 1'b0;
      bl_q    <= '0;
      thr_q   <= '0;
    end else begin
      if (ctl_i.load) begin
        first_q <= 1'b1;
      end else if (ctl_i.step) begin
        first_q <= 1'b0;
      end
      if (ctl_i.step) begin
        phase_q <= phase_d;
        wl_q    <= wl_d;
        rl_q    <= rl_d;
        arm_q   <= arm_d;
        outst_q <= outst_d;
        arb_q   <= arb_d;
        ovf_q   <= ovf_d;
        bl_q    <= bl_d;
        thr_q   <= thr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      it_cmd_q  <= cmd_i;
      it_addr_q <= target_addr_i;
      it_txc_q  <= CountBits'(tx_count_i);
      it_rxc_q  <= CountBits'(rx_count_i);
      it_byte_q <= data_byte_i;
      it_al_q   <= arb_lost_i;
      it_ov_q   <= overrun_i;
    end
    if (ctl_i.step) begin
      res_q <= res_d;
    end
  end

  `I2CSEQ_ASSERT_IMPL(dp_outst_bound, 1'b1, outst_q <= BatchW'(BatchLimit))
  `I2CSEQ_ASSERT_NEXT(dp_last_read_clears, ctl_i.step && emit && res_d.is_read && res_d.stop, rl_q == '0)
  `I2CSEQ_ASSERT_NEXT(dp_restart_first_only, ctl_i.step && !first_q, !res_q.restart)

endmodule

`default_nettype wire

[hdl/i2cseq_ctrl.sv]
// Controller: input and output handshake and step sequencing.
`default_nettype none

module i2cseq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  output logic                  valid_o,
  input  logic                  stall_i,
  output i2cseq_pkg::seq_cmd_t  ctl_o,
  input  i2cseq_pkg::seq_stat_t stat_i
);
  import i2cseq_pkg::*;

  `include "i2c_master_transfer_sequencer_unit_assert.svh"

  // Bit 1: a step is pending, bit 0: output register full.
  localparam logic [1:0] ST_IDLE     = 2'b00;
  localparam logic [1:0] ST_OUT      = 2'b01;
  localparam logic [1:0] ST_WORK     = 2'b10;
  localparam logic [1:0] ST_WORK_OUT = 2'b11;

  logic [1:0] state_q, state_d;
  logic [1:0] after_step;

  always_comb begin
    priority if (stat_i.emit && stat_i.more) begin
      after_step = ST_WORK_OUT;
    end else if (stat_i.emit) begin
      after_step = ST_OUT;
    end else begin
      after_step = ST_IDLE;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o.load = 1'b0;
    ctl_o.step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_WORK;
        end
      end
      ST_OUT: begin
        if (valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = stall_i ? ST_WORK_OUT : ST_WORK;
        end else if (!stall_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_WORK: begin
        ctl_o.step = 1'b1;
        state_d    = after_step;
      end
      ST_WORK_OUT: begin
        if (!stall_i) begin
          ctl_o.step = 1'b1;
          state_d    = after_step;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign stall_o = (state_q == ST_WORK) || (state_q == ST_WORK_OUT);
  assign valid_o = (state_q == ST_OUT) || (state_q == ST_WORK_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `I2CSEQ_ASSERT_NEXT(ctrl_load_then_work, ctl_o.load, state_q == ST_WORK || state_q == ST_WORK_OUT)
  `I2CSEQ_ASSERT_NEXT(ctrl_emit_shows, ctl_o.step && stat_i.emit, valid_o)
  `I2CSEQ_ASSERT_NEXT(ctrl_final_step_frees, ctl_o.step && !stat_i.more, !stall_o)
  `I2CSEQ_ASSERT_IMPL(ctrl_no_load_busy, stall_o, !ctl_o.load)

endmodule

`default_nettype wire

[hdl/i2c_master_transfer_sequencer_unit.sv]
// Top level of the I2C master write-then-read transfer sequencer.
`default_nettype none

// Turns start, transmit-empty, received-byte, stop and bus-error events into
// the result stream of an I2C write-then-read transfer: set target, write and
// read command words, received bytes, done and failed. Each accepted event is
// first latched, then stepped once per result it causes, or once if it causes
// none; the datapath produces one result per cycle into a single output
// register while the output is not stalled. The next event is taken while the
// final result of the previous one still waits at the output. A read batch
// holds at most min(FIFO depth, 16) words; last_o marks the final result of
// each event. There is no configuration port.
module i2c_master_transfer_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event channel
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [9:0]  target_addr_i,
  input  logic [15:0] tx_count_i,
  input  logic [15:0] rx_count_i,
  input  logic [7:0]  data_byte_i,
  input  logic        arb_lost_i,
  input  logic        overrun_i,
  // result channel
  output logic        valid_o,
  input  logic        stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_o,
  output logic        is_read_o,
  output logic        stop_o,
  output logic        restart_o,
  output logic [3:0]  rx_threshold_o,
  output logic [9:0]  addr_out_o,
  output logic        err_arb_lost_o,
  output logic        err_overrun_o,
  output logic        last_o
);
  import i2cseq_pkg::*;

  seq_cmd_t  ctl;
  seq_stat_t stat;
  res_t      res;

  // Sequence latching and stepping; owns both handshakes.
  i2cseq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .ctl_o   (ctl),
    .stat_i  (stat)
  );

  // Hold transfer state and build each result.
  i2cseq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .cmd_i         (cmd_i),
    .target_addr_i (target_addr_i),
    .tx_count_i    (tx_count_i),
    .rx_count_i    (rx_count_i),
    .data_byte_i   (data_byte_i),
    .arb_lost_i    (arb_lost_i),
    .overrun_i     (overrun_i),
    .res_o         (res)
  );

  assign kind_o         = res.kind;
  assign data_o         = res.data;
  assign is_read_o      = res.is_read;
  assign stop_o         = res.stop;
  assign restart_o      = res.restart;
  assign rx_threshold_o = res.thr;
  assign addr_out_o     = res.addr;
  assign err_arb_lost_o = res.err_arb;
  assign err_overrun_o  = res.err_ovr;
  assign last_o         = res.last;

endmodule

`default_nettype wire
